### design/dgbp_pkg.sv
// Package for the direction-gated block prefetcher.
// Holds the shared types, opcode, phase, decision and register index codes.
// Depends on nothing; every other design file uses it by scoped names.
package dgbp_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned BLOCK_W   = 48;
  localparam int unsigned HANDLE_W  = 64;
  localparam int unsigned PAGE_W    = 10;
  localparam int unsigned DEC_W     = 4;
  localparam int unsigned LEN_W     = 31;
  localparam int unsigned CFG_IDX_W = 8;

  // Opcodes of an input transaction.
  localparam logic [OPCODE_W-1:0] OP_BUILD  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FAULT  = 2'd2;

  // Decision codes reported with every result.
  localparam logic [DEC_W-1:0] DEC_PHASE_SET    = 4'd0;
  localparam logic [DEC_W-1:0] DEC_NOT_BUILD    = 4'd1;
  localparam logic [DEC_W-1:0] DEC_NO_BLOCK     = 4'd2;
  localparam logic [DEC_W-1:0] DEC_SAME_BLOCK   = 4'd3;
  localparam logic [DEC_W-1:0] DEC_NO_HISTORY   = 4'd4;
  localparam logic [DEC_W-1:0] DEC_NO_DIRECTION = 4'd5;
  localparam logic [DEC_W-1:0] DEC_ZERO_TARGET  = 4'd6;
  localparam logic [DEC_W-1:0] DEC_DUPLICATE    = 4'd7;
  localparam logic [DEC_W-1:0] DEC_ISSUED       = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFETCH_LENGTH = 8'd1;

  // Register reset values (2 MiB each).
  localparam logic [LEN_W-1:0] BLOCK_SIZE_RST      = 31'd2097152;
  localparam logic [LEN_W-1:0] PREFETCH_LENGTH_RST = 31'd2097152;

  // Prefetch phase.
  typedef enum logic [1:0] {
    PH_UNKNOWN = 2'd0,
    PH_BUILD   = 2'd1,
    PH_SEARCH  = 2'd2
  } phase_t;

  // One input item.
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [BLOCK_W-1:0]  end_addr;
    logic [HANDLE_W-1:0] space_handle;
    logic [PAGE_W-1:0]   span_first;
    logic [PAGE_W-1:0]   span_outer;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [PAGE_W-1:0]   region_first;
    logic [PAGE_W-1:0]   region_outer;
    logic [DEC_W-1:0]    decision;
    logic                issue;
    logic [BLOCK_W-1:0]  target_address;
    logic [HANDLE_W-1:0] target_space;
    logic [LEN_W-1:0]    target_length;
  } result_t;

  // Configuration register values.
  typedef struct packed {
    logic [LEN_W-1:0] block_size;
    logic [LEN_W-1:0] prefetch_length;
  } cfg_t;

endpackage

### design/dgbp_if.sv
// Channel interfaces of the direction-gated block prefetcher.
// Input, result and configuration channels, each with valid and ready.
// Depends on dgbp_pkg for the field widths.

interface dgbp_in_if;
  logic                           valid;
  logic                           ready;
  logic [dgbp_pkg::OPCODE_W-1:0]  opcode;
  logic [dgbp_pkg::BLOCK_W-1:0]   end_addr;
  logic [dgbp_pkg::HANDLE_W-1:0]  space_handle;
  logic [dgbp_pkg::PAGE_W-1:0]    span_first;
  logic [dgbp_pkg::PAGE_W-1:0]    span_outer;

  modport source (output valid, opcode, end_addr, space_handle, span_first, span_outer,
                  input ready);
  modport sink (input valid, opcode, end_addr, space_handle, span_first, span_outer,
                output ready);
endinterface

interface dgbp_out_if;
  logic                           valid;
  logic                           ready;
  logic [dgbp_pkg::PAGE_W-1:0]    region_first;
  logic [dgbp_pkg::PAGE_W-1:0]    region_outer;
  logic [dgbp_pkg::DEC_W-1:0]     decision;
  logic                           issue;
  logic [dgbp_pkg::BLOCK_W-1:0]   target_address;
  logic [dgbp_pkg::HANDLE_W-1:0]  target_space;
  logic [dgbp_pkg::LEN_W-1:0]     target_length;

  modport source (output valid, region_first, region_outer, decision, issue,
                  target_address, target_space, target_length, input ready);
  modport sink (input valid, region_first, region_outer, decision, issue,
                target_address, target_space, target_length, output ready);
endinterface

interface dgbp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dgbp_pkg::CFG_IDX_W-1:0] index;
  logic [dgbp_pkg::LEN_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/direction_gated_block_prefetcher_top.sv
// Top level of the direction-gated block prefetcher.
// Input register, decision engine, result register and configuration registers.
// Depends on dgbp_pkg, dgbp_if, dgbp_cfg_regs and dgbp_engine.
//
// Usage:
//   in_ch carries one hint per transaction: an opcode (build phase, search
//   phase or fault) with the faulting block end, space handle and the
//   maximum page region. out_ch returns exactly one result transaction per
//   input transaction, in order, with a decision code and, when issue is
//   set, the cross-block prefetch target, handle and length.
//   cfg_ch writes block_size (index 0) and prefetch_length (index 1), always
//   ready; the user must write it only while the block is idle (not enforced).
// Timing:
//   An accepted transaction passes the input register, then the engine into
//   the result register, and shows on out_ch from there. One transaction
//   per cycle is sustained while out_ch.ready is high; the only loop is the
//   phase, history and last target update, which finishes in the same cycle.
// Reset and stalls:
//   Reset clears both valid flags, the phase to unknown, the history and
//   last target to zero, and the registers to 2 MiB. When out_ch.ready is
//   low the result holds, the input register holds one more transaction,
//   and in_ch.ready drops until the result is taken.
module direction_gated_block_prefetcher_top #(
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic       clk,
  input  logic       rst_n,
  dgbp_in_if.sink    in_ch,
  dgbp_out_if.source out_ch,
  dgbp_cfg_if.sink   cfg_ch
);

  dgbp_pkg::cfg_t    cfg;
  dgbp_pkg::item_t   item_r;
  dgbp_pkg::result_t res;
  dgbp_pkg::result_t res_r;
  logic              in_valid_r;
  logic              out_valid_r;
  logic              advance;
  logic              fire;

  // The pipeline moves when the result register is empty or being taken.
  assign advance     = !out_valid_r || out_ch.ready;
  assign fire        = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.opcode       <= in_ch.opcode;
      item_r.end_addr     <= in_ch.end_addr;
      item_r.space_handle <= in_ch.space_handle;
      item_r.span_first   <= in_ch.span_first;
      item_r.span_outer   <= in_ch.span_outer;
    end
  end

  dgbp_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  dgbp_engine #(
    .ADDR_BITS (ADDR_BITS)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.region_first   = res_r.region_first;
  assign out_ch.region_outer   = res_r.region_outer;
  assign out_ch.decision       = res_r.decision;
  assign out_ch.issue          = res_r.issue;
  assign out_ch.target_address = res_r.target_address;
  assign out_ch.target_space   = res_r.target_space;
  assign out_ch.target_length  = res_r.target_length;

endmodule

### design/dgbp_cfg_regs.sv
// Configuration registers of the direction-gated block prefetcher.
// Holds block_size and prefetch_length; depends on dgbp_pkg and dgbp_cfg_if.
module dgbp_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  dgbp_cfg_if.sink        cfg_ch,
  output dgbp_pkg::cfg_t  cfg
);

  dgbp_pkg::cfg_t cfg_r;

  // Writes are always taken.
  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  // Register write decode; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_size      <= dgbp_pkg::BLOCK_SIZE_RST;
      cfg_r.prefetch_length <= dgbp_pkg::PREFETCH_LENGTH_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        dgbp_pkg::REG_BLOCK_SIZE:      cfg_r.block_size      <= cfg_ch.data;
        dgbp_pkg::REG_PREFETCH_LENGTH: cfg_r.prefetch_length <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

### design/dgbp_engine.sv
// Decision engine of the direction-gated block prefetcher.
// Holds phase, block end history and last target; computes one result per item.
// Depends on dgbp_pkg.
module dgbp_engine #(
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  dgbp_pkg::item_t    item,
  input  dgbp_pkg::cfg_t     cfg,
  output dgbp_pkg::result_t  res
);

  // The oldest history slot never influences a result, so only the two
  // newest block ends are kept.
  dgbp_pkg::phase_t     phase_r, phase_nxt;
  logic [ADDR_BITS-1:0] hist1_r, hist1_nxt;
  logic [ADDR_BITS-1:0] hist2_r, hist2_nxt;
  logic [ADDR_BITS-1:0] last_target_r, last_target_nxt;

  logic [ADDR_BITS-1:0] bend;
  logic [ADDR_BITS-1:0] diff1;
  logic [ADDR_BITS-1:0] diff2;
  logic [ADDR_BITS-1:0] target;
  logic                 dir_ok;
  logic                 going_up;

  // Address arithmetic, modulo 2^ADDR_BITS.
  assign bend     = ADDR_BITS'(item.end_addr);
  assign diff1    = hist2_r - hist1_r;
  assign diff2    = bend - hist2_r;
  assign going_up = ~diff2[ADDR_BITS-1];
  assign dir_ok   = (diff1 != '0) && (diff2 != '0)
                    && (diff1[ADDR_BITS-1] == diff2[ADDR_BITS-1]);
  assign target   = going_up ? (bend + ADDR_BITS'(1))
                             : (bend - ADDR_BITS'(cfg.block_size));

  // Decision and next state.
  always_comb begin
    res             = '0;
    phase_nxt       = phase_r;
    hist1_nxt       = hist1_r;
    hist2_nxt       = hist2_r;
    last_target_nxt = last_target_r;
    case (item.opcode)
      dgbp_pkg::OP_BUILD:  phase_nxt = dgbp_pkg::PH_BUILD;
      dgbp_pkg::OP_SEARCH: phase_nxt = dgbp_pkg::PH_SEARCH;
      dgbp_pkg::OP_FAULT: begin
        res.region_first = item.span_first;
        res.region_outer = item.span_outer;
        if (phase_r != dgbp_pkg::PH_BUILD) begin
          res.decision = dgbp_pkg::DEC_NOT_BUILD;
        end else if ((item.space_handle == '0) || (bend == '0)) begin
          res.decision = dgbp_pkg::DEC_NO_BLOCK;
        end else if (bend == hist2_r) begin
          res.decision = dgbp_pkg::DEC_SAME_BLOCK;
        end else begin
          hist1_nxt = hist2_r;
          hist2_nxt = bend;
          if ((hist1_r == '0) || (hist2_r == '0)) begin
            res.decision = dgbp_pkg::DEC_NO_HISTORY;
          end else if (!dir_ok) begin
            res.decision = dgbp_pkg::DEC_NO_DIRECTION;
          end else if (target == '0) begin
            res.decision = dgbp_pkg::DEC_ZERO_TARGET;
          end else if (target == last_target_r) begin
            res.decision = dgbp_pkg::DEC_DUPLICATE;
          end else begin
            last_target_nxt    = target;
            res.decision       = dgbp_pkg::DEC_ISSUED;
            res.issue          = 1'b1;
            res.target_address = dgbp_pkg::BLOCK_W'(target);
            res.target_space   = item.space_handle;
            res.target_length  = cfg.prefetch_length;
          end
        end
      end
      default: ;
    endcase
  end

  // State registers advance only when the item moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= dgbp_pkg::PH_UNKNOWN;
      hist1_r       <= '0;
      hist2_r       <= '0;
      last_target_r <= '0;
    end else if (fire) begin
      phase_r       <= phase_nxt;
      hist1_r       <= hist1_nxt;
      hist2_r       <= hist2_nxt;
      last_target_r <= last_target_nxt;
    end
  end

  // An issued target becomes the duplicate filter for the next fault.
  a_last_target: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.issue |=> last_target_r == $past(target))
    else $error("last target not recorded after issue");

  // A history shift makes the faulting block end the newest entry.
  a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (res.decision == dgbp_pkg::DEC_NO_HISTORY
             || res.decision == dgbp_pkg::DEC_NO_DIRECTION
             || res.decision == dgbp_pkg::DEC_ZERO_TARGET
             || res.decision == dgbp_pkg::DEC_DUPLICATE
             || res.decision == dgbp_pkg::DEC_ISSUED)
    |=> hist2_r == $past(bend) && hist1_r == $past(hist2_r))
    else $error("history not shifted");

  // A build event always leaves the engine in build phase.
  a_build_phase: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.opcode == dgbp_pkg::OP_BUILD |=> phase_r == dgbp_pkg::PH_BUILD)
    else $error("build event did not set build phase");

  // Without a fault in build phase nothing can be issued.
  a_issue_gate: assert property (@(posedge clk) disable iff (!rst_n)
    res.issue |-> item.opcode == dgbp_pkg::OP_FAULT && phase_r == dgbp_pkg::PH_BUILD
                  && res.target_address != '0)
    else $error("issue outside a build phase fault");

endmodule
